@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of the keyframe segment locator.
// Clocked, reset-gated implication forms; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold in the cycle ante holds.
`define KFSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define KFSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/kfsl_pkg.sv @@
// Shared types, codes and defaults for the keyframe segment locator.
// No dependencies; the divider, top level and checker refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package kfsl_pkg;

    localparam int TIME_W            = 32;
    localparam int SLOT_W            = 8;
    localparam int KEY_W             = 8;
    localparam int FRAC_W            = 17;
    localparam int CNT_W             = 9;
    localparam int DEF_MAX_KEYS      = 256;
    localparam int DEF_FRACTION_BITS = 16;

    // request codes carried in req_type
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [FRAC_W-1:0] t_frac;
    typedef logic [CNT_W-1:0]  t_count;

    typedef struct packed {
        logic  req_type;
        t_slot key_slot;
        t_time key_time;
        t_time query_time;
    } t_req;

    typedef struct packed {
        t_key  lower_key;
        t_key  upper_key;
        t_frac fraction;
        logic  before_first;
        logic  zero_span;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_SEARCH,
        S_T1,
        S_T2,
        S_DIV
    } t_state;

endpackage

`default_nettype wire

@@ sv/kfsl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the keyframe time table.
`timescale 1ns / 1ps
`default_nettype none

module kfsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/kfsl_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle into a shift register.
// Needs num < den; gives (num << FRACTION_BITS) / den. Uses kfsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kfsl_div #(
    parameter int FRACTION_BITS = kfsl_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire kfsl_pkg::t_time          i_num,
    input  wire kfsl_pkg::t_time          i_den,
    output logic                          o_done,
    output logic [FRACTION_BITS-1:0]      o_quot
);

    localparam int CW = $clog2(FRACTION_BITS + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_count;
    kfsl_pkg::t_time             r_rem;
    kfsl_pkg::t_time             r_den;
    logic [FRACTION_BITS-1:0]    r_quot;

    logic [kfsl_pkg::TIME_W:0]   rem2;
    logic [kfsl_pkg::TIME_W:0]   diff;
    logic                        take;

    always_comb begin
        rem2 = {r_rem, 1'b0};
        diff = rem2 - {1'b0, r_den};
        take = (rem2 >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_count <= CW'(FRACTION_BITS);
        end else if (r_busy) begin
            r_count <= r_count - CW'(1);
            if (r_count == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the low word is enough
            r_rem  <= take ? diff[kfsl_pkg::TIME_W-1:0] : rem2[kfsl_pkg::TIME_W-1:0];
            r_quot <= {r_quot[FRACTION_BITS-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ sv/keyframe_segment_locator_top.sv @@
// Keyframe segment locator: key-time table, binary search sequencer and serial divider.
// Uses kfsl_pkg, kfsl_ram and kfsl_div.
`timescale 1ns / 1ps
`default_nettype none

// A word is taken when start is high and busy is low. A write word (req_type 0) stores
// key_time at key_slot and busy stays low; it gives no result. A query word holds busy
// high until its result is on o_result with o_result_valid high for exactly one cycle;
// the receiver cannot stall, so capture it then. A query makes up to log2(MAX_KEYS)
// binary-search steps, one table read per step, and the serial divider then works out
// the fraction bit by bit. Queries that clamp, saturate, hit a single key or raise a
// flag skip the divider. busy falls in the strobe cycle. key_count is written over the
// cfg channel while the block is idle; the table has no reset, so only slots written
// since power-up may be searched.
module keyframe_segment_locator_top #(
    parameter int MAX_KEYS      = kfsl_pkg::DEF_MAX_KEYS,
    parameter int FRACTION_BITS = kfsl_pkg::DEF_FRACTION_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire kfsl_pkg::t_req    i_req,
    output logic                   o_result_valid,
    output kfsl_pkg::t_result      o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire kfsl_pkg::t_count  i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam logic [FRACTION_BITS:0] ONE_FULL = {1'b1, {FRACTION_BITS{1'b0}}};

    kfsl_pkg::t_state   r_state, n_state;
    kfsl_pkg::t_count   r_key_count;
    logic               r_out_valid, n_out_valid;
    kfsl_pkg::t_result  r_result, n_result;
    kfsl_pkg::t_time    r_q, n_q;
    kfsl_pkg::t_time    r_t1, n_t1;
    logic [IDX_W-1:0]   r_lo, n_lo;
    logic [IDX_W-1:0]   r_hi, n_hi;
    logic [IDX_W-1:0]   r_mid, n_mid;

    logic               accept;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    kfsl_pkg::t_time    ram_rdata;
    logic [IDX_W-1:0]   cnt_hi;

    logic               s_brk;
    logic [IDX_W-1:0]   s_lo, s_hi, s_mid;
    logic [IDX_W:0]     s_sum;
    logic [IDX_W-1:0]   up_idx;

    logic               div_start;
    kfsl_pkg::t_time    div_num, div_den;
    logic               div_done;
    logic [FRACTION_BITS-1:0] div_quot;
    kfsl_pkg::t_frac    frac_one;

    assign accept    = start && !busy && i_rst_n;
    assign ram_we    = accept && (i_req.req_type == kfsl_pkg::REQ_WRITE)
                       && (32'(i_req.key_slot) < 32'(MAX_KEYS));
    assign ram_waddr = IDX_W'(32'(i_req.key_slot));
    assign frac_one  = kfsl_pkg::t_frac'(ONE_FULL);
    assign up_idx    = r_lo + IDX_W'(1);
    assign div_num   = r_q - r_t1;
    assign div_den   = ram_rdata - r_t1;

    // last active index, with the count clamped to 1..MAX_KEYS
    always_comb begin
        if (r_key_count == '0) begin
            cnt_hi = '0;
        end else if (32'(r_key_count) > 32'(MAX_KEYS)) begin
            cnt_hi = IDX_W'(MAX_KEYS - 1);
        end else begin
            cnt_hi = IDX_W'(32'(r_key_count) - 32'd1);
        end
    end

    // one search step on the entry read at r_mid
    always_comb begin
        s_lo  = r_lo;
        s_hi  = r_hi;
        s_brk = 1'b0;
        if (ram_rdata < r_q) begin
            s_lo = r_mid;
        end else if (ram_rdata > r_q) begin
            s_hi = r_mid;
        end else begin
            s_lo  = r_mid;
            s_brk = 1'b1;
        end
        s_sum = {1'b0, s_lo} + {1'b0, s_hi};
        s_mid = s_sum[IDX_W:1];
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = 1'b0;
        n_result    = r_result;
        n_q         = r_q;
        n_t1        = r_t1;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        ram_raddr   = cnt_hi;
        div_start   = 1'b0;
        case (r_state)
            kfsl_pkg::S_IDLE: begin
                ram_raddr = cnt_hi;
                if (accept && (i_req.req_type == kfsl_pkg::REQ_QUERY)) begin
                    n_q     = i_req.query_time;
                    n_lo    = '0;
                    n_hi    = cnt_hi;
                    n_state = kfsl_pkg::S_LAST;
                end
            end
            kfsl_pkg::S_LAST: begin
                ram_raddr = '0;
                if ((r_q >= ram_rdata) || (r_hi == '0)) begin
                    // clamp at the last key; a single key always lands here
                    n_out_valid           = 1'b1;
                    n_result.lower_key    = kfsl_pkg::t_key'(32'(r_hi));
                    n_result.upper_key    = kfsl_pkg::t_key'(32'(r_hi));
                    n_result.fraction     = frac_one;
                    n_result.before_first = 1'b0;
                    n_result.zero_span    = 1'b0;
                    n_state               = kfsl_pkg::S_IDLE;
                end else if (r_hi > IDX_W'(1)) begin
                    ram_raddr = r_hi >> 1;
                    n_mid     = r_hi >> 1;
                    n_state   = kfsl_pkg::S_SEARCH;
                end else begin
                    n_state = kfsl_pkg::S_T1;
                end
            end
            kfsl_pkg::S_SEARCH: begin
                n_lo = s_lo;
                n_hi = s_hi;
                if (!s_brk && ((s_hi - s_lo) > IDX_W'(1))) begin
                    ram_raddr = s_mid;
                    n_mid     = s_mid;
                end else begin
                    ram_raddr = s_lo;
                    n_state   = kfsl_pkg::S_T1;
                end
            end
            kfsl_pkg::S_T1: begin
                n_t1      = ram_rdata;
                ram_raddr = up_idx;
                n_state   = kfsl_pkg::S_T2;
            end
            kfsl_pkg::S_T2: begin
                ram_raddr             = up_idx;
                n_result.lower_key    = kfsl_pkg::t_key'(32'(r_lo));
                n_result.upper_key    = kfsl_pkg::t_key'(32'(up_idx));
                n_result.before_first = (r_q < r_t1);
                n_result.zero_span    = (ram_rdata <= r_t1);
                n_result.fraction     = '0;
                if ((r_q < r_t1) || (ram_rdata <= r_t1)) begin
                    n_out_valid = 1'b1;
                    n_state     = kfsl_pkg::S_IDLE;
                end else if (r_q >= ram_rdata) begin
                    // quotient would reach 1.0: saturate
                    n_result.fraction = frac_one;
                    n_out_valid       = 1'b1;
                    n_state           = kfsl_pkg::S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = kfsl_pkg::S_DIV;
                end
            end
            kfsl_pkg::S_DIV: begin
                if (div_done) begin
                    n_result.fraction = kfsl_pkg::t_frac'(div_quot);
                    n_out_valid       = 1'b1;
                    n_state           = kfsl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kfsl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kfsl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_key_count <= kfsl_pkg::t_count'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_key_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_q      <= n_q;
        r_t1     <= n_t1;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
    end

    kfsl_ram #(
        .WIDTH (kfsl_pkg::TIME_W),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.key_time),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kfsl_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign busy           = (r_state != kfsl_pkg::S_IDLE);
    assign o_cfg_ready    = !busy;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire

@@ sv/kfsl_checker.sv @@
// Port-level checks for the keyframe segment locator, bound to the top level.
// Uses kfsl_pkg and the macros in assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kfsl_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire kfsl_pkg::t_req    i_req,
    input wire logic              o_result_valid,
    input wire kfsl_pkg::t_result o_result
);

    logic q_accept;
    logic flagged;
    logic idx_ok;

    assign q_accept = start && !busy && (i_req.req_type == kfsl_pkg::REQ_QUERY);
    assign flagged  = o_result.before_first || o_result.zero_span;
    assign idx_ok   = (o_result.upper_key == o_result.lower_key)
                      || (o_result.upper_key == kfsl_pkg::t_key'(o_result.lower_key + 8'd1));

    // a query always takes the block out of idle
    `KFSL_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, q_accept, busy)
    // one query gives one strobe, never two in a row
    `KFSL_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    // a flagged segment reports no position
    `KFSL_ASSERT_NOW(a_flag_frac, i_clk, i_rst_n, o_result_valid && flagged,
                     o_result.fraction == '0)
    // the upper key is the lower key or the next one
    `KFSL_ASSERT_NOW(a_key_pair, i_clk, i_rst_n, o_result_valid, idx_ok)

endmodule

bind keyframe_segment_locator_top kfsl_checker u_kfsl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_req          (i_req),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire
